/* hdl/brte_pkg.sv */
// brte_pkg: item types, ascii constants and character lookup functions
// for the byte to radix text encoder; no dependencies
package brte_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [6:0] text_char;
        logic       last_char;
        logic       bad_radix;
    } t_out_item;

    localparam logic [7:0] RADIX_RESET = 8'd64;
    localparam logic [7:0] RADIX_B64   = 8'd64;
    localparam logic [7:0] RADIX_MIN   = 8'd2;
    localparam logic [7:0] RADIX_MAX   = 8'd36;

    localparam logic [1:0] REG_RADIX = 2'b00;

    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_PLUS    = 7'h2b;
    localparam logic [6:0] CH_SLASH   = 7'h2f;
    localparam logic [6:0] CH_PAD     = 7'h3d;
    localparam logic [6:0] CH_NUL     = 7'h00;

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] w;
        w = {1'b0, v};
        if (v < 6'd26) begin
            return CH_UPPER_A + w;
        end else if (v < 6'd52) begin
            return CH_LOWER_A + w - 7'd26;
        end else if (v < 6'd62) begin
            return CH_ZERO + w - 7'd52;
        end else if (v == 6'd62) begin
            return CH_PLUS;
        end else begin
            return CH_SLASH;
        end
    endfunction

    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] w;
        w = {1'b0, d};
        if (d < 6'd10) begin
            return CH_ZERO + w;
        end else begin
            return CH_LOWER_A + w - 7'd10;
        end
    endfunction

    // index of the last digit: digit count minus one
    function automatic logic [2:0] digit_last(input logic [7:0] radix);
        if (radix == 8'd2) begin
            return 3'd7;
        end else if (radix == 8'd3) begin
            return 3'd5;
        end else if (radix <= 8'd6) begin
            return 3'd3;
        end else if (radix <= 8'd15) begin
            return 3'd2;
        end else begin
            return 3'd1;
        end
    endfunction

endpackage

/* hdl/brte_div.sv */
// brte_div: iterative restoring divider, one quotient bit per cycle
// 8-bit dividend by 6-bit divisor; no package dependencies
module brte_div (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_dividend,
    input  logic [5:0] i_divisor,
    output logic       o_done,
    output logic [7:0] o_quot,
    output logic [5:0] o_rem
);

    logic       r_busy;
    logic       r_done;
    logic [2:0] r_cnt;
    logic [5:0] r_rem;
    logic [7:0] r_quot;
    logic [5:0] r_divisor;

    logic [6:0] rem_sh;
    logic [6:0] diff;
    logic       ge;
    logic [5:0] n_rem;

    assign rem_sh = {r_rem, r_quot[7]};
    assign diff   = rem_sh - {1'b0, r_divisor};
    assign ge     = rem_sh >= {1'b0, r_divisor};
    assign n_rem  = ge ? diff[5:0] : rem_sh[5:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= 6'd0;
            r_quot    <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[6:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("done without a finished run");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_divisor != 6'd0) |-> r_rem < r_divisor)
        else $error("remainder not below divisor");
`endif

endmodule

/* hdl/byte_to_radix_text_encoder_top.sv */
// byte_to_radix_text_encoder_top: byte stream to base64 or radix digit text
// depends on brte_pkg and brte_div
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_in  (data_byte, last_byte)
//  out     | output    | o_out_valid / i_out_stall  | o_out (text_char, last_char, bad_radix)
//  cfg     | input     | psel penable pwrite pready | paddr, pwdata, prdata (radix)
//
// base 64 or bad radix: one character per cycle while the output is not stalled (up to 4)
// digit bases: the digits come one after another from the shared divider, which
// loads each dividend and then spends 8 steps per digit; base 2 is the worst case
// synchronous active-low reset; radix returns to 64, base64 group state clears
// a stalled output holds the emit sequencer; input is taken only when idle
module byte_to_radix_text_encoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  brte_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output brte_pkg::t_out_item o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import brte_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_radix;
    logic [1:0] r_phase;
    logic [3:0] r_left;
    logic [1:0] n_phase;
    logic [3:0] n_left;
    logic [6:0] r_buf [0:7];
    logic [2:0] r_last_idx;
    logic [2:0] r_wr_idx;
    logic [2:0] r_rd_idx;
    logic       r_bad;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       accept;
    logic       mode_b64;
    logic       mode_dig;
    logic       out_load;
    logic [1:0] phase;
    logic [6:0] b64c [0:3];
    logic [2:0] b64_last;

    logic       div_start;
    logic [7:0] div_dividend;
    logic       div_done;
    logic [7:0] div_quot;
    logic [5:0] div_rem;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_RADIX) ? {24'd0, r_radix} : 32'd0;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign mode_b64   = (r_radix == RADIX_B64);
    assign mode_dig   = (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX);
    assign phase      = (r_phase == 2'd3) ? 2'd0 : r_phase;
    assign out_load   = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    // base64 characters for the accepted byte, including flush and padding
    always_comb begin
        b64c[0]  = CH_PAD;
        b64c[1]  = CH_PAD;
        b64c[2]  = CH_PAD;
        b64c[3]  = CH_PAD;
        b64_last = 3'd0;
        n_phase  = r_phase;
        n_left   = r_left;
        unique case (phase)
            2'd1: begin
                b64c[0] = b64_char({r_left[1:0], i_in.data_byte[7:4]});
                if (i_in.last_byte) begin
                    b64c[1]  = b64_char({i_in.data_byte[3:0], 2'b00});
                    b64_last = 3'd2;
                    n_phase  = 2'd0;
                    n_left   = 4'd0;
                end else begin
                    n_phase = 2'd2;
                    n_left  = i_in.data_byte[3:0];
                end
            end
            2'd2: begin
                b64c[0]  = b64_char({r_left[3:0], i_in.data_byte[7:6]});
                b64c[1]  = b64_char(i_in.data_byte[5:0]);
                b64_last = 3'd1;
                n_phase  = 2'd0;
                n_left   = 4'd0;
            end
            default: begin
                b64c[0] = b64_char(i_in.data_byte[7:2]);
                if (i_in.last_byte) begin
                    b64c[1]  = b64_char({i_in.data_byte[1:0], 4'b0000});
                    b64_last = 3'd3;
                    n_phase  = 2'd0;
                    n_left   = 4'd0;
                end else begin
                    n_phase = 2'd1;
                    n_left  = {2'b00, i_in.data_byte[1:0]};
                end
            end
        endcase
    end

    assign div_start    = (accept && !mode_b64 && mode_dig) ||
                          ((r_state == ST_DIV) && div_done && (r_wr_idx != 3'd0));
    assign div_dividend = (r_state == ST_IDLE) ? i_in.data_byte : div_quot;

    brte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_radix[5:0]),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (!mode_b64 && mode_dig) ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV: begin
                if (div_done && (r_wr_idx == 3'd0)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && (r_rd_idx == r_last_idx)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_radix     <= RADIX_RESET;
            r_phase     <= 2'd0;
            r_left      <= 4'd0;
            r_out_valid <= 1'b0;
            r_last_idx  <= 3'd0;
            r_wr_idx    <= 3'd0;
            r_rd_idx    <= 3'd0;
            r_bad       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && (paddr == REG_RADIX)) begin
                r_radix <= pwdata[7:0];
            end
            if (accept) begin
                r_rd_idx <= 3'd0;
                if (mode_b64) begin
                    r_phase    <= n_phase;
                    r_left     <= n_left;
                    r_last_idx <= b64_last;
                    r_bad      <= 1'b0;
                end else if (mode_dig) begin
                    r_last_idx <= digit_last(r_radix);
                    r_wr_idx   <= digit_last(r_radix);
                    r_bad      <= 1'b0;
                end else begin
                    r_last_idx <= 3'd0;
                    r_bad      <= 1'b1;
                end
            end
            if ((r_state == ST_DIV) && div_done && (r_wr_idx != 3'd0)) begin
                r_wr_idx <= r_wr_idx - 3'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_rd_idx    <= r_rd_idx + 3'd1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // character buffer and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (mode_b64) begin
                r_buf[0] <= b64c[0];
                r_buf[1] <= b64c[1];
                r_buf[2] <= b64c[2];
                r_buf[3] <= b64c[3];
            end else if (!mode_dig) begin
                r_buf[0] <= CH_NUL;
            end
        end
        if ((r_state == ST_DIV) && div_done) begin
            r_buf[r_wr_idx] <= digit_char(div_rem);
        end
        if (out_load) begin
            r_out.text_char <= r_buf[r_rd_idx];
            r_out.last_char <= (r_rd_idx == r_last_idx);
            r_out.bad_radix <= r_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_DIV || r_state == ST_EMIT))
        else $error("accepted item did not start work");
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.bad_radix) |-> r_out.last_char)
        else $error("bad radix item not marked last");
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_rd_idx <= r_last_idx))
        else $error("emit index past last character");
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("base64 group phase out of range");
`endif

endmodule
